FILE: design/cfq_pkg.sv
// ----------------------------------------------------------------------------
// Circular FIFO queue package
// Shared sizes, command and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package cfq_pkg;

  // Number of physical storage slots.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Width of the capacity register and of the entry count.
  localparam int unsigned CNT_W = 5;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_SPARE   = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OVERFLOW    = 2'd1,
    ST_UNDERFLOW   = 2'd2,
    ST_NOT_CREATED = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // Execute the request on the inputs this cycle.
    logic load_out; // Read the store and load the response register.
  } cfq_ctrl_t;

endpackage

FILE: design/cfq_intf.sv
// ----------------------------------------------------------------------------
// Circular FIFO queue channel interfaces
// Request, response and capacity write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface cfq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink (input valid, input command, input push_value, output ready);
endinterface

interface cfq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] front_value;
  logic [31:0] rear_value;
  logic [4:0]  entry_count;
  logic        is_empty;
  logic        is_full;

  modport source (output valid, output status, output front_value, output rear_value,
                  output entry_count, output is_empty, output is_full, input ready);
  modport sink (input valid, input status, input front_value, input rear_value,
                input entry_count, input is_empty, input is_full, output ready);
endinterface

interface cfq_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] queue_capacity;

  modport source (output valid, output queue_capacity, input ready);
  modport sink (input valid, input queue_capacity, output ready);
endinterface

FILE: design/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// Circular FIFO queue controller
// Sequences accept, store read and response hand-off for each request.
// ----------------------------------------------------------------------------
module cfq_ctrl
  import cfq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output cfq_ctrl_t ctrl_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   slot_free;

  // The response register can take new data once it is empty or being drained.
  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  assign ctrl_o.accept   = (state_q == S_IDLE) && req_valid_i;
  assign ctrl_o.load_out = (state_q == S_READ) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (rsp_valid_q && rsp_ready_i) begin
            rsp_valid_q <= 1'b0;
          end
          if (req_valid_i) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (slot_free) begin
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/cfq_datapath.sv
// ----------------------------------------------------------------------------
// Circular FIFO queue datapath
// Word store, head/tail pointers, occupancy, capacity and response register.
// ----------------------------------------------------------------------------
module cfq_datapath
  import cfq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfq_ctrl_t         ctrl_i,
  input  logic [1:0]        command_i,
  input  logic [WORD_W-1:0] push_value_i,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_capacity_i,
  output logic [1:0]        status_o,
  output logic [WORD_W-1:0] front_value_o,
  output logic [WORD_W-1:0] rear_value_o,
  output logic [CNT_W-1:0]  entry_count_o,
  output logic              is_empty_o,
  output logic              is_full_o
);

  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0] cap_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  status_e          stat_q, stat_d;

  logic [CNT_W-1:0] cap_use;
  logic             enq_ok;
  logic             deq_ok;
  logic [PTR_W-1:0] last_idx;

  logic [1:0]        out_status_q;
  logic [WORD_W-1:0] out_front_q;
  logic [WORD_W-1:0] out_rear_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_empty_q;
  logic              out_full_q;

  // Advance a slot index, wrapping at the capacity in use.
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] inc;
    inc = (CNT_W+1)'(slot) + (CNT_W+1)'(1);
    return (inc >= {1'b0, cap}) ? '0 : inc[PTR_W-1:0];
  endfunction

  assign cap_use = (cap_q > DepthCnt) ? DepthCnt : cap_q;

  always_comb begin
    enq_ok = 1'b0;
    deq_ok = 1'b0;
    stat_d = ST_OK;
    priority if (cap_use == '0) begin
      stat_d = ST_NOT_CREATED;
    end else if (command_i == CMD_ENQUEUE) begin
      if (occ_q >= cap_use) begin
        stat_d = ST_OVERFLOW;
      end else begin
        enq_ok = 1'b1;
      end
    end else if (command_i == CMD_DEQUEUE) begin
      if (occ_q == '0) begin
        stat_d = ST_UNDERFLOW;
      end else begin
        deq_ok = 1'b1;
      end
    end else begin
      stat_d = ST_OK;
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    if (enq_ok) begin
      tail_d = next_slot(tail_q, cap_use);
      occ_d  = occ_q + CNT_W'(1);
    end
    if (deq_ok) begin
      head_d = next_slot(head_q, cap_use);
      occ_d  = occ_q - CNT_W'(1);
    end
  end

  // The newest word sits just behind the tail, wrapping to the last used slot.
  assign last_idx = (tail_q == '0) ? PTR_W'(cap_use - CNT_W'(1)) : tail_q - PTR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
      stat_q <= ST_OK;
    end else if (cfg_we_i) begin
      cap_q  <= cfg_capacity_i;
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else if (ctrl_i.accept) begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && enq_ok) begin
      mem[tail_q] <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_status_q <= stat_q;
      out_count_q  <= occ_q;
      out_empty_q  <= (occ_q == '0);
      out_full_q   <= (cap_use != '0) && (occ_q == cap_use);
      if (occ_q == '0) begin
        out_front_q <= '1;
        out_rear_q  <= '1;
      end else begin
        out_front_q <= mem[head_q];
        out_rear_q  <= mem[last_idx];
      end
    end
  end

  assign status_o      = out_status_q;
  assign front_value_o = out_front_q;
  assign rear_value_o  = out_rear_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;
  assign is_full_o     = out_full_q;

endmodule

FILE: design/circular_fifo_queue.sv
// ----------------------------------------------------------------------------
// Circular FIFO queue
// Run-time sized circular queue of signed 32-bit words with status response.
// ----------------------------------------------------------------------------
// Usage: every request on req_i carries a command (enqueue, dequeue or query)
// and a push value. Each request produces exactly one response on rsp_o with
// the status and the front, rear, count, empty and full view after the request.
// The capacity is written through cfg_i while the block is idle; any write,
// even of the same value, empties the queue. A capacity of zero means the
// queue does not exist and every request then reports not-created. Values
// above the physical depth of 16 entries are clamped to 16.
// Timing: a request is taken at an edge where the controller is idle. The
// controller then enters its read state; once the output register is free,
// the word store is read at the head and at the slot behind the tail and
// the response register is loaded, which raises response valid. A new
// request is taken only after the read state has loaded the response.
// Stalls: while a response waits in the output register the next request is
// still taken; its store read waits until the output register is drained.
// Reset: capacity, pointers and count clear; the word store is not cleared.
// ----------------------------------------------------------------------------
module circular_fifo_queue
  import cfq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cfq_req_if.sink   req_i,
  cfq_rsp_if.source rsp_o,
  cfq_cfg_if.sink   cfg_i
);

  cfq_ctrl_t ctrl;

  // Capacity writes always taken, unchecked: user must write only while idle.
  assign cfg_i.ready = 1'b1;

  cfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  cfq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .command_i      (req_i.command),
    .push_value_i   (req_i.push_value),
    .cfg_we_i       (cfg_i.valid),
    .cfg_capacity_i (cfg_i.queue_capacity),
    .status_o       (rsp_o.status),
    .front_value_o  (rsp_o.front_value),
    .rear_value_o   (rsp_o.rear_value),
    .entry_count_o  (rsp_o.entry_count),
    .is_empty_o     (rsp_o.is_empty),
    .is_full_o      (rsp_o.is_full)
  );

endmodule

FILE: tb/sv/circular_fifo_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular FIFO queue testbench
// Drives enqueue, dequeue, query and spare requests under several capacities and
// stall patterns, predicts every response, and compares it field by field.
// ----------------------------------------------------------------------------
module circular_fifo_queue_test;
  import cfq_pkg::*;

  // One response as the block should report it after a request.
  typedef struct {
    status_e     status;
    logic [31:0] front_value;
    logic [31:0] rear_value;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        is_full;
  } queue_view_t;

  // Idle cycles waited after the last response to catch any stray output.
  localparam int unsigned SETTLE_CYCLES = 4;

  logic clk;
  logic rst_n;

  cfq_req_if req_if ();
  cfq_rsp_if rsp_if ();
  cfq_cfg_if cfg_if ();

  circular_fifo_queue dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the queue: storage, pointers, occupancy and the capacity
  // register as last written.
  logic [31:0] shadow_words [DEPTH];
  int unsigned shadow_head;
  int unsigned shadow_tail;
  int unsigned shadow_count;
  logic [4:0]  shadow_capacity;

  // Responses still owed by the block, oldest first.
  queue_view_t pending_views[$];
  int unsigned mismatch_count;

  // Percent of cycles in which each side holds off.
  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;

  always #2 clk = ~clk;

  // Apply one request to the shadow queue and return the response it causes.
  function automatic queue_view_t predict_request(command_e cmd, logic [31:0] word);
    queue_view_t view;
    int unsigned cap;
    int unsigned last;
    cap = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
    view.status = ST_OK;
    view.front_value = '1;
    view.rear_value = '1;
    if (cap == 0) begin
      view.status = ST_NOT_CREATED;
    end else if (cmd == CMD_ENQUEUE) begin
      if (shadow_count >= cap) begin
        view.status = ST_OVERFLOW;
      end else begin
        shadow_words[shadow_tail] = word;
        shadow_tail = (shadow_tail + 1 >= cap) ? 0 : shadow_tail + 1;
        shadow_count++;
      end
    end else if (cmd == CMD_DEQUEUE) begin
      if (shadow_count == 0) begin
        view.status = ST_UNDERFLOW;
      end else begin
        shadow_head = (shadow_head + 1 >= cap) ? 0 : shadow_head + 1;
        shadow_count--;
      end
    end
    // Query and the spare code leave the state alone.
    if (cap != 0 && shadow_count != 0) begin
      last = (shadow_tail == 0) ? cap - 1 : shadow_tail - 1;
      view.front_value = shadow_words[shadow_head];
      view.rear_value = shadow_words[last];
    end
    view.entry_count = shadow_count[4:0];
    view.is_empty = (shadow_count == 0);
    view.is_full = (cap != 0 && shadow_count == cap);
    return view;
  endfunction

  function automatic void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      mismatch_count++;
    end
  endfunction

  // Response checker: every response taken is held against the oldest
  // prediction still waiting.
  always @(posedge clk) begin
    queue_view_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_views.size() == 0) begin
        $error("response with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_views.pop_front();
        compare_field("status", 32'(want.status), 32'(rsp_if.status));
        compare_field("front_value", want.front_value, rsp_if.front_value);
        compare_field("rear_value", want.rear_value, rsp_if.rear_value);
        compare_field("entry_count", 32'(want.entry_count), 32'(rsp_if.entry_count));
        compare_field("is_empty", 32'(want.is_empty), 32'(rsp_if.is_empty));
        compare_field("is_full", 32'(want.is_full), 32'(rsp_if.is_full));
      end
    end
  end

  // Response back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    rsp_if.ready = ($urandom_range(0, 99) >= rsp_idle_pct);
  end

  // Send one request. Valid stays high from one request to the next unless
  // the sender decides to idle, so back-to-back requests are exercised too.
  task automatic send_request(command_e cmd, logic [31:0] word);
    @(negedge clk);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.command = cmd;
    req_if.push_value = word;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_views.push_back(predict_request(cmd, word));
  endtask

  // Stop sending and wait until every response owed has come back.
  task automatic wait_drained();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register with the block idle. Any write empties the
  // queue, so the shadow pointers are cleared along with it.
  task automatic write_capacity(logic [4:0] cap);
    wait_drained();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.queue_capacity = cap;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    shadow_capacity = cap;
    shadow_head = 0;
    shadow_tail = 0;
    shadow_count = 0;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Straight after reset the capacity is zero and no queue exists: every
  // command, the spare code included, must report not-created.
  task automatic test_not_created();
    send_request(CMD_ENQUEUE, 32'h7fff_ffff);
    send_request(CMD_DEQUEUE, 32'h0000_0000);
    send_request(CMD_QUERY, 32'hffff_ffff);
    send_request(CMD_SPARE, 32'h8000_0000);
  endtask

  // A two-entry queue walks through underflow, the extreme words, overflow,
  // the spare code and a pointer wrap.
  task automatic test_small_queue();
    write_capacity(5'd2);
    send_request(CMD_DEQUEUE, 32'h0000_0000);
    send_request(CMD_ENQUEUE, 32'h8000_0000);
    send_request(CMD_ENQUEUE, 32'h7fff_ffff);
    send_request(CMD_ENQUEUE, 32'h0000_0000);
    send_request(CMD_QUERY, 32'h1234_5678);
    send_request(CMD_SPARE, 32'h0000_0000);
    send_request(CMD_DEQUEUE, 32'h0000_0000);
    send_request(CMD_ENQUEUE, 32'hffff_ffff);
    send_request(CMD_DEQUEUE, 32'h0000_0000);
    send_request(CMD_DEQUEUE, 32'h0000_0000);
    send_request(CMD_DEQUEUE, 32'h0000_0000);
  endtask

  // Capacity writes: a one-entry queue, a rewrite of the same value that must
  // empty a loaded queue, and a write of zero that removes the queue.
  task automatic test_capacity_writes();
    write_capacity(5'd1);
    send_request(CMD_ENQUEUE, 32'h0f0f_0f0f);
    send_request(CMD_ENQUEUE, 32'hf0f0_f0f0);
    write_capacity(5'd1);
    send_request(CMD_QUERY, 32'h0000_0000);
    send_request(CMD_ENQUEUE, 32'h5555_aaaa);
    write_capacity(5'd0);
    send_request(CMD_QUERY, 32'h0000_0000);
    // The all-ones capacity is clamped to the physical depth.
    write_capacity(5'd31);
    send_request(CMD_ENQUEUE, 32'haaaa_5555);
    send_request(CMD_DEQUEUE, 32'h0000_0000);
  endtask

  // Random traffic. Capacities are drawn mostly small so full and empty come
  // up often, with a share at or above the physical depth. The enqueue
  // weight swings between phases of filling and draining so that overflow
  // and underflow are both reached.
  task automatic test_random_traffic(int unsigned snd_pct, int unsigned rcv_pct,
                                     int unsigned total);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned enq_weight;
    int unsigned pick;
    logic [4:0]  cap;
    logic [31:0] word;
    command_e    cmd;
    req_idle_pct = snd_pct;
    rsp_idle_pct = rcv_pct;
    sent = 0;
    while (sent < total) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) cap = 5'd0;
      else if (pick <= 5) cap = 5'($urandom_range(1, 4));
      else if (pick <= 7) cap = 5'($urandom_range(5, 16));
      else if (pick == 8) cap = 5'd16;
      else cap = 5'($urandom_range(17, 31));
      write_capacity(cap);
      seg_len = $urandom_range(40, 120);
      for (int unsigned i = 0; i < seg_len && sent < total; i++) begin
        if (i % 20 == 0) enq_weight = ($urandom_range(0, 1) != 0) ? 80 : 25;
        pick = $urandom_range(0, 99);
        if (pick < 3) cmd = CMD_QUERY;
        else if (pick < 5) cmd = CMD_SPARE;
        else if (pick < 5 + enq_weight * 95 / 100) cmd = CMD_ENQUEUE;
        else cmd = CMD_DEQUEUE;
        pick = $urandom_range(0, 19);
        if (pick == 0) word = 32'h8000_0000;
        else if (pick == 1) word = 32'h7fff_ffff;
        else if (pick == 2) word = 32'hffff_ffff;
        else if (pick == 3) word = 32'h0000_0000;
        else word = $urandom();
        send_request(cmd, word);
        sent++;
        // Now and then the sender holds back until the block has answered
        // everything, so requests also arrive into a quiet pipeline.
        if ($urandom_range(0, 99) < 2) wait_drained();
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_QUERY;
    req_if.push_value = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.queue_capacity = '0;
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    mismatch_count = 0;
    shadow_capacity = '0;
    shadow_head = 0;
    shadow_tail = 0;
    shadow_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_not_created();
    test_small_queue();
    test_capacity_writes();
    test_random_traffic(11, 88, 600);
    test_random_traffic(88, 11, 600);
    test_random_traffic(0, 0, 600);

    rsp_idle_pct = 0;
    wait_drained();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 2000 requests with
  // heavy stalls on either side.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
design/cfq_pkg.sv
design/cfq_intf.sv
design/cfq_ctrl.sv
design/cfq_datapath.sv
design/circular_fifo_queue.sv
tb/sv/circular_fifo_queue_test.sv
